/* hdl/dss_pkg.sv */
// Shared constants for the two-stack shared-array block.
`default_nettype none
package dss_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W   = 3;
  localparam int DATA_W = 8;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_ONE = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_TWO = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_ONE  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_TWO  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP_ONE = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP_TWO = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage
`default_nettype wire

/* hdl/dual_stack_shared_array.sv */
// Top level: two LIFO stacks growing toward each other in one shared RAM.
//
//   channel | dir | tdata (low bit up)            | tuser   | tlast
//   in_     | in  | operation[2:0], data_in[10:3] | -       | -
//   out_    | out | data_out[7:0]                 | status  | last
//
// An item is taken into the op and data registers, then executed: a push
// writes the RAM and registers its result; a pop reads the RAM (registered
// read data) and registers the read word as its result. A dump of n
// entries streams one entry a cycle from the RAM read port unless stalled.
// Reset clears both counts; RAM contents are not cleared.
// A stalled output holds the block in place; the next item is taken once the
// previous one has been executed, even while its last result still waits.
`default_nettype none
module dual_stack_shared_array #(
  parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // operation[2:0], data_in[10:3], zero[15:11]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // data_out[7:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast   // last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [dss_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [dss_pkg::DATA_W-1:0]   din_r, din_nxt;
  logic [CW-1:0]                lower_r, lower_nxt;
  logic [CW-1:0]                upper_r, upper_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic                         down_r, down_nxt;
  logic                         last_r, last_nxt;

  logic                         ov_r, ov_nxt;
  logic [dss_pkg::DATA_W-1:0]   od_r, od_nxt;
  logic [dss_pkg::STAT_W-1:0]   os_r, os_nxt;
  logic                         ol_r, ol_nxt;

  logic                         we, re;
  logic [AW-1:0]                waddr, raddr;
  logic [dss_pkg::DATA_W-1:0]   rdata;

  logic                         slot_free;
  logic                         full;
  logic [CW-1:0]                step_ptr;

  dss_ram #(
    .WIDTH (dss_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (din_r),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = os_r;
  assign out_tlast  = ol_r;

  assign slot_free = !ov_r || out_tready;
  assign full      = ({1'b0, lower_r} + {1'b0, upper_r}) >= {1'b0, DEPTH_C};
  assign step_ptr  = down_r ? (ptr_r - CW'(1)) : (ptr_r + CW'(1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    din_nxt   = din_r;
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    ptr_nxt   = ptr_r;
    down_nxt  = down_r;
    last_nxt  = last_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    os_nxt    = os_r;
    ol_nxt    = ol_r;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = lower_r[AW-1:0];
    raddr     = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tdata[2:0];
          din_nxt   = in_tdata[10:3];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
          od_nxt    = '0;
          os_nxt    = dss_pkg::ST_OK;
          ol_nxt    = 1'b1;
          case (op_r)
            dss_pkg::OP_PUSH_ONE, dss_pkg::OP_PUSH_TWO: begin
              ov_nxt = 1'b1;
              if (full) begin
                os_nxt = dss_pkg::ST_FULL;
              end else if (op_r == dss_pkg::OP_PUSH_ONE) begin
                we        = 1'b1;
                waddr     = lower_r[AW-1:0];
                lower_nxt = lower_r + CW'(1);
              end else begin
                we        = 1'b1;
                waddr     = AW'(TOP_C - upper_r);
                upper_nxt = upper_r + CW'(1);
              end
            end
            dss_pkg::OP_POP_ONE, dss_pkg::OP_DUMP_ONE: begin
              if (lower_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = dss_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = AW'(lower_r - CW'(1));
                ptr_nxt   = lower_r - CW'(1);
                down_nxt  = 1'b1;
                state_nxt = S_READ;
                if (op_r == dss_pkg::OP_POP_ONE) begin
                  lower_nxt = lower_r - CW'(1);
                  last_nxt  = 1'b1;
                end else begin
                  last_nxt  = (lower_r == CW'(1));
                end
              end
            end
            dss_pkg::OP_POP_TWO, dss_pkg::OP_DUMP_TWO: begin
              if (upper_r == '0) begin
                ov_nxt = 1'b1;
                os_nxt = dss_pkg::ST_EMPTY;
              end else begin
                re        = 1'b1;
                raddr     = AW'(DEPTH_C - upper_r);
                ptr_nxt   = DEPTH_C - upper_r;
                down_nxt  = 1'b0;
                state_nxt = S_READ;
                if (op_r == dss_pkg::OP_POP_TWO) begin
                  upper_nxt = upper_r - CW'(1);
                  last_nxt  = 1'b1;
                end else begin
                  last_nxt  = (upper_r == CW'(1));
                end
              end
            end
            default: begin
              // unused operation codes: no result
            end
          endcase
        end
      end

      S_READ: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          od_nxt = rdata;
          os_nxt = dss_pkg::ST_OK;
          ol_nxt = last_r;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            // next entry of the dump
            re       = 1'b1;
            raddr    = step_ptr[AW-1:0];
            ptr_nxt  = step_ptr;
            last_nxt = down_r ? (step_ptr == '0) : (step_ptr == TOP_C);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lower_r <= '0;
      upper_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      ov_r    <= ov_nxt;
    end
    op_r   <= op_nxt;
    din_r  <= din_nxt;
    ptr_r  <= ptr_nxt;
    down_r <= down_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
    ol_r   <= ol_nxt;
  end

endmodule
`default_nettype wire

/* hdl/dss_ram.sv */
// Generic one-write, one-read RAM with registered read data.
`default_nettype none
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
